// File: rtl/ptmq_pkg.sv
// ptmq_pkg: shared field widths, operation and status codes, and the
// command/status structs between the queue controller and its datapath.
// No dependencies.
package ptmq_pkg;

    localparam int OP_W     = 2;
    localparam int NODE_W   = 6;
    localparam int TASK_W   = 4;
    localparam int SENDER_W = 4;
    localparam int LEN_W    = 16;
    localparam int TYPE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0] TASK_COUNT_RST = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_SEND   = 2'd1,
        OP_URGENT = 2'd2,
        OP_RECV   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BADTASK = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic q_step;
        logic n_step;
        logic w_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic task_ok;
        logic node_ok;
        logic nonempty;
    } stat_t;

endpackage

// File: rtl/ptmq_if.sv
// ptmq_req_if / ptmq_rsp_if: valid/ready channels for requests and results.
// Depends on ptmq_pkg for field widths.
interface ptmq_req_if;
    logic                                valid;
    logic                                ready;
    logic [ptmq_pkg::OP_W-1:0]           op;
    logic [ptmq_pkg::NODE_W-1:0]         node;
    logic [ptmq_pkg::TASK_W-1:0]         task_req;
    logic [ptmq_pkg::SENDER_W-1:0]       sender;
    logic [ptmq_pkg::LEN_W-1:0]          msg_len;
    logic signed [ptmq_pkg::TYPE_W-1:0]  msg_type;

    modport source (output valid, op, node, task_req, sender, msg_len, msg_type,
                    input ready);
    modport sink   (input valid, op, node, task_req, sender, msg_len, msg_type,
                    output ready);
endinterface

interface ptmq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [ptmq_pkg::STATUS_W-1:0]       status;
    logic [ptmq_pkg::NODE_W-1:0]         out_node;
    logic [ptmq_pkg::LEN_W-1:0]          out_len;
    logic signed [ptmq_pkg::TYPE_W-1:0]  out_type;
    logic [ptmq_pkg::SENDER_W-1:0]       out_sender;

    modport source (output valid, status, out_node, out_len, out_type, out_sender,
                    input ready);
    modport sink   (input valid, status, out_node, out_len, out_type, out_sender,
                    output ready);
endinterface

// File: rtl/ptmq_datapath.sv
// ptmq_datapath: request register, task_count register, queue head/tail
// memories, node link and metadata memories, and the result register.
// Depends on ptmq_pkg; driven by ptmq_ctrl through cmd_t.
module ptmq_datapath #(
    parameter int NUM_NODES = 64,
    parameter int MAX_TASKS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptmq_pkg::cmd_t                      cmd,
    output ptmq_pkg::stat_t                     stat,
    input  logic                                cfg_wen,
    input  logic [ptmq_pkg::CNT_W-1:0]          cfg_wdata,
    input  logic [ptmq_pkg::OP_W-1:0]           op,
    input  logic [ptmq_pkg::NODE_W-1:0]         node,
    input  logic [ptmq_pkg::TASK_W-1:0]         task_req,
    input  logic [ptmq_pkg::SENDER_W-1:0]       sender,
    input  logic [ptmq_pkg::LEN_W-1:0]          msg_len,
    input  logic signed [ptmq_pkg::TYPE_W-1:0]  msg_type,
    output logic [ptmq_pkg::STATUS_W-1:0]       status,
    output logic [ptmq_pkg::NODE_W-1:0]         out_node,
    output logic [ptmq_pkg::LEN_W-1:0]          out_len,
    output logic signed [ptmq_pkg::TYPE_W-1:0]  out_type,
    output logic [ptmq_pkg::SENDER_W-1:0]       out_sender
);

    localparam int NW = $clog2(NUM_NODES);
    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LW = NW + 1;
    // link with the end mark set means no next node
    localparam logic [LW-1:0] NO_LINK = {1'b1, {NW{1'b0}}};

    // request register
    ptmq_pkg::op_t                      op_reg;
    logic [ptmq_pkg::NODE_W-1:0]        node_reg;
    logic [ptmq_pkg::TASK_W-1:0]        task_reg;
    logic [ptmq_pkg::SENDER_W-1:0]      sender_reg;
    logic [ptmq_pkg::LEN_W-1:0]         len_in_reg;
    logic [ptmq_pkg::TYPE_W-1:0]        type_in_reg;

    logic [ptmq_pkg::CNT_W-1:0]         task_count_reg;
    logic [MAX_TASKS-1:0]               nonempty_reg;
    logic                               ne_reg;

    logic [NW-1:0] head_mem [MAX_TASKS];
    logic [NW-1:0] tail_mem [MAX_TASKS];
    logic [LW-1:0] link_mem [NUM_NODES];
    logic [ptmq_pkg::LEN_W-1:0]    len_mem  [NUM_NODES];
    logic [ptmq_pkg::TYPE_W-1:0]   kind_mem [NUM_NODES];
    logic [ptmq_pkg::SENDER_W-1:0] src_mem  [NUM_NODES];

    logic [NW-1:0]                 head_rd_reg;
    logic [NW-1:0]                 tail_rd_reg;
    logic [LW-1:0]                 link_rd_reg;
    logic [ptmq_pkg::LEN_W-1:0]    len_rd_reg;
    logic [ptmq_pkg::TYPE_W-1:0]   kind_rd_reg;
    logic [ptmq_pkg::SENDER_W-1:0] src_rd_reg;

    ptmq_pkg::status_t             status_reg;
    logic [ptmq_pkg::NODE_W-1:0]   out_node_reg;
    logic [ptmq_pkg::LEN_W-1:0]    out_len_reg;
    logic [ptmq_pkg::TYPE_W-1:0]   out_type_reg;
    logic [ptmq_pkg::SENDER_W-1:0] out_sender_reg;

    ptmq_pkg::status_t             res_status;
    logic [ptmq_pkg::NODE_W-1:0]   res_node;
    logic [ptmq_pkg::LEN_W-1:0]    res_len;
    logic [ptmq_pkg::TYPE_W-1:0]   res_type;
    logic [ptmq_pkg::SENDER_W-1:0] res_sender;

    logic          task_ok;
    logic          node_ok;
    logic [TW-1:0] tidx;
    logic [NW-1:0] nidx;
    logic          ne_now;
    logic          link_end;
    logic          do_create;
    logic          do_send;
    logic          do_urg;
    logic          do_recv;
    logic          head_we;
    logic [NW-1:0] head_wd;
    logic          tail_we;
    logic          link_we;
    logic [NW-1:0] link_wa;
    logic [LW-1:0] link_wd;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= ptmq_pkg::op_t'(op);
            node_reg    <= node;
            task_reg    <= task_req;
            sender_reg  <= sender;
            len_in_reg  <= msg_len;
            type_in_reg <= msg_type;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= ptmq_pkg::TASK_COUNT_RST;
        end
        else if (cfg_wen)
        begin
            task_count_reg <= cfg_wdata;
        end
    end

    assign task_ok = ({1'b0, task_reg} < task_count_reg)
                     && (int'(task_reg) < MAX_TASKS);
    assign node_ok = int'(node_reg) < NUM_NODES;
    assign tidx    = TW'(task_reg);
    assign nidx    = NW'(node_reg);
    assign ne_now  = nonempty_reg[tidx];
    assign link_end = link_rd_reg[LW-1];

    assign do_create = (op_reg == ptmq_pkg::OP_CREATE) && node_ok;
    assign do_send   = (op_reg == ptmq_pkg::OP_SEND) && task_ok && node_ok;
    assign do_urg    = (op_reg == ptmq_pkg::OP_URGENT) && task_ok && node_ok;
    assign do_recv   = (op_reg == ptmq_pkg::OP_RECV) && task_ok && ne_reg;

    assign stat.op       = op_reg;
    assign stat.task_ok  = task_ok;
    assign stat.node_ok  = node_ok;
    assign stat.nonempty = ne_now;

    // queue flags: set by a send or urgent send, cleared when the last node is popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
        end
        else if (cmd.q_step && (do_send || do_urg))
        begin
            nonempty_reg[tidx] <= 1'b1;
        end
        else if (cmd.w_step && do_recv && link_end)
        begin
            nonempty_reg[tidx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_step)
        begin
            ne_reg <= ne_now;
        end
    end

    // head and tail memories, read-first
    always_comb
    begin
        head_we = (cmd.q_step && (do_urg || (do_send && !ne_now)))
                  || (cmd.w_step && do_recv && !link_end);
        head_wd = cmd.q_step ? nidx : link_rd_reg[NW-1:0];
        tail_we = cmd.q_step && (do_send || (do_urg && !ne_now));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_step)
        begin
            head_rd_reg <= head_mem[tidx];
            tail_rd_reg <= tail_mem[tidx];
        end
        if (head_we)
        begin
            head_mem[tidx] <= head_wd;
        end
        if (tail_we)
        begin
            tail_mem[tidx] <= nidx;
        end
    end

    // link memory: clear on the first step, chain on the write step
    always_comb
    begin
        link_we = 1'b0;
        link_wa = nidx;
        link_wd = NO_LINK;
        if (cmd.q_step && (do_create || do_send || (do_urg && !ne_now)))
        begin
            link_we = 1'b1;
        end
        else if (cmd.w_step && do_send && ne_reg)
        begin
            link_we = 1'b1;
            link_wa = tail_rd_reg;
            link_wd = {1'b0, nidx};
        end
        else if (cmd.w_step && do_urg && ne_reg)
        begin
            link_we = 1'b1;
            link_wd = {1'b0, head_rd_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.n_step)
        begin
            link_rd_reg <= link_mem[head_rd_reg];
            len_rd_reg  <= len_mem[head_rd_reg];
            kind_rd_reg <= kind_mem[head_rd_reg];
            src_rd_reg  <= src_mem[head_rd_reg];
        end
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.q_step && do_create)
        begin
            len_mem[nidx]  <= len_in_reg;
            kind_mem[nidx] <= type_in_reg;
        end
        if (cmd.q_step && (do_send || do_urg))
        begin
            src_mem[nidx] <= sender_reg;
        end
    end

    always_comb
    begin
        res_status = ptmq_pkg::ST_OK;
        res_node   = '0;
        res_len    = '0;
        res_type   = '0;
        res_sender = '0;
        if (op_reg != ptmq_pkg::OP_CREATE && !task_ok)
        begin
            res_status = ptmq_pkg::ST_BADTASK;
        end
        else if (op_reg == ptmq_pkg::OP_RECV)
        begin
            if (!ne_reg)
            begin
                res_status = ptmq_pkg::ST_EMPTY;
            end
            else
            begin
                res_node   = ptmq_pkg::NODE_W'(head_rd_reg);
                res_len    = len_rd_reg;
                res_type   = kind_rd_reg;
                res_sender = src_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg     <= res_status;
            out_node_reg   <= res_node;
            out_len_reg    <= res_len;
            out_type_reg   <= res_type;
            out_sender_reg <= res_sender;
        end
    end

    assign status     = status_reg;
    assign out_node   = out_node_reg;
    assign out_len    = out_len_reg;
    assign out_type   = out_type_reg;
    assign out_sender = out_sender_reg;

endmodule

// File: rtl/ptmq_ctrl.sv
// ptmq_ctrl: sequencer for one request at a time and the result valid flag.
// Depends on ptmq_pkg; drives ptmq_datapath through cmd_t.
module ptmq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  ptmq_pkg::stat_t stat,
    output ptmq_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUEUE,
        S_NODE,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_QUEUE;
                end
            end
            S_QUEUE:
            begin
                cmd.q_step = 1'b1;
                if (stat.op == ptmq_pkg::OP_CREATE || !stat.task_ok)
                begin
                    state_next = S_DONE;
                end
                else if (stat.op == ptmq_pkg::OP_RECV)
                begin
                    state_next = stat.nonempty ? S_NODE : S_DONE;
                end
                else
                begin
                    state_next = stat.node_ok ? S_WRITE : S_DONE;
                end
            end
            S_NODE:
            begin
                cmd.n_step = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.w_step = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // when the output is free, result moves to the output register, next request may enter
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    in_ready       = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_QUEUE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (state_reg == S_IDLE || state_reg == S_DONE))
        else $error("request accepted mid operation");

    a_node_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NODE) |=> (state_reg == S_WRITE))
        else $error("node read not followed by write step");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.q_step, cmd.n_step, cmd.w_step, cmd.out_load}))
        else $error("overlapping datapath steps");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// File: rtl/per_task_message_queues_core.sv
// per_task_message_queues_core: one linked message queue per task over a node pool.
// A request is loaded, then passes S_QUEUE and S_DONE for create, rejected tasks,
// empty receive and out-of-range nodes; sends add S_WRITE; a receive that pops adds
// S_NODE, S_WRITE. Requests are taken one at a time, with registered head/tail and
// node memory reads, a single link memory write port; S_DONE stalls on a held result.
// Reset (async, active low) empties every queue and sets task_count to 16.
module per_task_message_queues_core #(
    parameter int NUM_NODES = 64,
    parameter int MAX_TASKS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [ptmq_pkg::CNT_W-1:0] cfg_wdata,
    ptmq_req_if.sink                   req,
    ptmq_rsp_if.source                 rsp
);

    ptmq_pkg::cmd_t  cmd;
    ptmq_pkg::stat_t stat;

    ptmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptmq_datapath #(
        .NUM_NODES (NUM_NODES),
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .op         (req.op),
        .node       (req.node),
        .task_req   (req.task_req),
        .sender     (req.sender),
        .msg_len    (req.msg_len),
        .msg_type   (req.msg_type),
        .status     (rsp.status),
        .out_node   (rsp.out_node),
        .out_len    (rsp.out_len),
        .out_type   (rsp.out_type),
        .out_sender (rsp.out_sender)
    );

endmodule
